### rtl/pccw_pkg.sv
// pccw_pkg: shared opcodes, field widths and the result record of the conflict window block
// no dependencies; compiled first
package pccw_pkg;

    localparam int OPCODE_W = 2;
    localparam int ID_W     = 6;
    localparam int CNT_W    = 7;
    localparam int THR_W    = 7;
    localparam int TOTAL_W  = 64;

    localparam logic [THR_W-1:0] THR_RESET = 7'd32;

    localparam logic [OPCODE_W-1:0] OP_REC_SUCCESS  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REC_CONFLICT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY        = 2'd2;

    typedef struct packed {
        logic               multi_write_ok;
        logic               is_tracked;
        logic [CNT_W-1:0]   recent_conflicts;
        logic [TOTAL_W-1:0] total_successes;
        logic [TOTAL_W-1:0] total_conflicts;
    } t_result;

endpackage

### rtl/per_command_conflict_window_top.sv
// per_command_conflict_window_top: per-command outcome window table with multi-write permit
// depends on pccw_pkg and pccw_update
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------------
//  request   | i_in_valid / o_in_ready    | i_opcode, i_command_id
//  result    | o_out_valid / i_out_ready  | o_multi_write_ok, o_is_tracked,
//            |                            | o_recent_conflicts, o_total_successes,
//            |                            | o_total_conflicts
//  config    | i_cfg_we (no wait)         | i_cfg_wdata (conflict threshold)
//
// a transaction is a read-modify-write: the accept edge reads the entry ram, then the
// modify step writes the modified entry back and loads the result register
// after reset a clearing pass writes every entry with o_in_ready low
// a stalled result holds the modify step until the output register frees up; the request
// side reopens as soon as the result is loaded, so one result can wait while the next
// request is taken
module per_command_conflict_window_top #(
    parameter int WINDOW       = 64,
    parameter int NUM_COMMANDS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pccw_pkg::THR_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pccw_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [pccw_pkg::ID_W-1:0]     i_command_id,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_multi_write_ok,
    output logic                          o_is_tracked,
    output logic [pccw_pkg::CNT_W-1:0]    o_recent_conflicts,
    output logic [pccw_pkg::TOTAL_W-1:0]  o_total_successes,
    output logic [pccw_pkg::TOTAL_W-1:0]  o_total_conflicts
);
    import pccw_pkg::*;

    localparam int PW = $clog2(WINDOW);
    localparam int AW = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1;

    // one table row: outcome bits, ring position, tracked flag, clear-slot count, totals
    typedef struct packed {
        logic [WINDOW-1:0]  win;
        logic [PW-1:0]      pos;
        logic               tracked;
        logic [CNT_W-1:0]   count;
        logic [TOTAL_W-1:0] succ;
        logic [TOTAL_W-1:0] conf;
    } t_entry;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;

    // entry ram, one write and one registered read per cycle
    t_entry r_table [NUM_COMMANDS];
    t_entry r_rd;

    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_addr;
    logic [OPCODE_W-1:0] r_op;
    logic                r_in_range;
    logic [THR_W-1:0]    r_thr;
    logic                r_out_valid;
    t_result             r_out;

    logic    in_acc;
    logic    in_range;
    logic    out_free;
    logic    mem_we;
    logic    upd_we;
    t_entry  upd_entry;
    t_entry  clr_entry;
    t_entry  mem_wdata;
    logic [AW-1:0] mem_waddr;
    t_result upd_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_command_id) < NUM_COMMANDS);
    assign out_free   = !r_out_valid || i_out_ready;

    // reset contents of a row: every slot clear, so all count as conflicts
    assign clr_entry.win     = '0;
    assign clr_entry.pos     = '0;
    assign clr_entry.tracked = 1'b0;
    assign clr_entry.count   = CNT_W'(WINDOW);
    assign clr_entry.succ    = '0;
    assign clr_entry.conf    = '0;

    // threshold register, written at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // read side: capture request and the addressed row at the accept edge
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd       <= r_table[AW'(i_command_id)];
            r_addr     <= AW'(i_command_id);
            r_op       <= i_opcode;
            r_in_range <= in_range;
        end
    end

    pccw_update #(
        .WINDOW (WINDOW)
    ) u_update (
        .i_op        (r_op),
        .i_in_range  (r_in_range),
        .i_threshold (r_thr),
        .i_win       (r_rd.win),
        .i_pos       (r_rd.pos),
        .i_tracked   (r_rd.tracked),
        .i_count     (r_rd.count),
        .i_succ      (r_rd.succ),
        .i_conf      (r_rd.conf),
        .o_we        (upd_we),
        .o_win       (upd_entry.win),
        .o_pos       (upd_entry.pos),
        .o_tracked   (upd_entry.tracked),
        .o_count     (upd_entry.count),
        .o_succ      (upd_entry.succ),
        .o_conf      (upd_entry.conf),
        .o_res       (upd_res)
    );

    // write side: clearing pass or write-back of the modified row
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = clr_entry;
        end else begin
            mem_we    = (r_state == S_EXEC) && out_free && upd_we;
            mem_waddr = r_addr;
            mem_wdata = upd_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in the modify cycle the load below decides the result valid
            if (r_out_valid && i_out_ready && (r_state != S_EXEC)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(NUM_COMMANDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // hold the row until the result register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= upd_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_multi_write_ok   = r_out.multi_write_ok;
    assign o_is_tracked       = r_out.is_tracked;
    assign o_recent_conflicts = r_out.recent_conflicts;
    assign o_total_successes  = r_out.total_successes;
    assign o_total_conflicts  = r_out.total_conflicts;

    // an accepted request closes the request side for the modify cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("request accepted while a row update is in flight");

    // the modify cycle always lands a result once the output register is free
    a_exec_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) && out_free |=> o_out_valid && o_in_ready)
        else $error("modify step did not produce a result");

    // an untracked entry never has totals and is always permitted
    a_untracked_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_tracked |->
            o_multi_write_ok && (o_total_successes == '0) && (o_total_conflicts == '0))
        else $error("untracked entry reports totals or a refusal");

    // clear-slot count never exceeds the window length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_recent_conflicts) <= WINDOW))
        else $error("recent conflict count beyond window length");

endmodule

### rtl/pccw_update.sv
// pccw_update: modify step of one table entry read-modify-write, and the result record
// depends on pccw_pkg
module pccw_update #(
    parameter int WINDOW = 64
) (
    input  logic [pccw_pkg::OPCODE_W-1:0] i_op,
    input  logic                          i_in_range,
    input  logic [pccw_pkg::THR_W-1:0]    i_threshold,
    input  logic [WINDOW-1:0]             i_win,
    input  logic [$clog2(WINDOW)-1:0]     i_pos,
    input  logic                          i_tracked,
    input  logic [pccw_pkg::CNT_W-1:0]    i_count,
    input  logic [pccw_pkg::TOTAL_W-1:0]  i_succ,
    input  logic [pccw_pkg::TOTAL_W-1:0]  i_conf,
    output logic                          o_we,
    output logic [WINDOW-1:0]             o_win,
    output logic [$clog2(WINDOW)-1:0]     o_pos,
    output logic                          o_tracked,
    output logic [pccw_pkg::CNT_W-1:0]    o_count,
    output logic [pccw_pkg::TOTAL_W-1:0]  o_succ,
    output logic [pccw_pkg::TOTAL_W-1:0]  o_conf,
    output pccw_pkg::t_result             o_res
);
    import pccw_pkg::*;

    localparam int PW = $clog2(WINDOW);

    logic is_succ;
    logic is_conf;
    logic is_rec;
    logic old_bit;

    assign is_succ = (i_op == OP_REC_SUCCESS);
    assign is_conf = (i_op == OP_REC_CONFLICT);
    assign is_rec  = is_succ || is_conf;
    assign old_bit = i_win[i_pos];

    assign o_we = is_rec && i_in_range;

    always_comb begin
        for (int k = 0; k < WINDOW; k++) begin
            o_win[k] = (is_rec && (PW'(k) == i_pos)) ? is_succ : i_win[k];
        end
    end

    always_comb begin
        if (!is_rec) begin
            o_pos = i_pos;
        end else if (i_pos == PW'(WINDOW - 1)) begin
            o_pos = '0;
        end else begin
            o_pos = i_pos + PW'(1);
        end
    end

    // conflicts count the clear slots; a slot flip moves the count by one
    always_comb begin
        o_count = i_count;
        if (is_succ && !old_bit) begin
            o_count = i_count - CNT_W'(1);
        end else if (is_conf && old_bit) begin
            o_count = i_count + CNT_W'(1);
        end
    end

    assign o_tracked = i_tracked || is_rec;
    assign o_succ    = is_succ ? (i_succ + TOTAL_W'(1)) : i_succ;
    assign o_conf    = is_conf ? (i_conf + TOTAL_W'(1)) : i_conf;

    always_comb begin
        if (!i_in_range) begin
            o_res.multi_write_ok   = 1'b1;
            o_res.is_tracked       = 1'b0;
            o_res.recent_conflicts = CNT_W'(WINDOW);
            o_res.total_successes  = '0;
            o_res.total_conflicts  = '0;
        end else begin
            o_res.multi_write_ok   = !o_tracked || (o_count < i_threshold);
            o_res.is_tracked       = o_tracked;
            o_res.recent_conflicts = o_count;
            o_res.total_successes  = o_succ;
            o_res.total_conflicts  = o_conf;
        end
    end

endmodule
